@@ design/olvd_pkg.sv @@
`timescale 1ns / 1ps

package olvd_pkg;

	localparam int unsigned ValueWidth = 32;

	// Command codes carried in the input transfer
	typedef enum logic [2:0] {
		CMD_INSERT    = 3'd0,
		CMD_DEL_MATCH = 3'd1,
		CMD_DEL_FIRST = 3'd2,
		CMD_DEL_LAST  = 3'd3,
		CMD_DUMP      = 3'd4
	} cmd_code_t;

	// Status codes carried in the output transfer
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]                   cmd;
		logic signed [ValueWidth-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic signed [ValueWidth-1:0] entry;
		logic                         last;
	} out_item_t;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		DP_NONE,
		DP_INSERT,
		DP_MATCH,
		DP_REMOVE,
		DP_POP_FRONT,
		DP_POP_BACK,
		DP_DUMP_START,
		DP_ROTATE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic found;
		logic dump_last;
	} dp_stat_t;

endpackage

@@ design/ordered_list_with_value_delete.sv @@
`timescale 1ns / 1ps

// Channel | Signals                       | Transfer when
// --------+-------------------------------+---------------------------
// input   | in_valid, in_ready, in_item   | in_valid && in_ready
// output  | out_valid, out_ready, out_item| out_valid && out_ready
//
// One command at a time. Insert, delete-first, delete-last, unused codes and
// errors give a registered result; delete-match first compares all cells,
// then closes the gap. A dump hands out one entry per cycle from the rotating
// cell row while the output does not stall.
// Reset (arst_n low) empties the list; the cells themselves are not cleared.
// The next command is taken once the previous result transfer has completed.

module ordered_list_with_value_delete import olvd_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	dp_cmd_t                      dp_cmd;
	dp_stat_t                     dp_stat;
	logic signed [ValueWidth-1:0] front;

	// Sequencer: decodes commands, issues datapath operations, owns the
	// output register
	olvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.front     (front)
	);

	// Cell row: per-cell compare, shift and rotate, plus the entry count
	olvd_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.value  (in_item.value),
		.stat   (dp_stat),
		.front  (front)
	);

endmodule

@@ design/olvd_dp.sv @@
`timescale 1ns / 1ps

module olvd_dp import olvd_pkg::*; #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	input  logic signed [ValueWidth-1:0] value,
	output dp_stat_t                     stat,
	output logic signed [ValueWidth-1:0] front
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);

	logic signed [ValueWidth-1:0] cells_q [CAPACITY];
	logic signed [ValueWidth-1:0] prev_w  [CAPACITY];
	logic signed [ValueWidth-1:0] next_w  [CAPACITY];
	logic [CAPACITY-1:0]          match_d;
	logic [CAPACITY-1:0]          match_q;
	logic [CAPACITY-1:0]          gap_w;
	logic [CAPACITY-1:0]          tail_w;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_m1;
	logic [IW-1:0]                idx_q;

	assign count_m1 = count_q - CW'(1);

	// Per-cell neighbors, compare and position flags
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign prev_w[g] = value;
		end else begin : g_body
			assign prev_w[g] = cells_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign next_w[g] = cells_q[0];
		end else begin : g_mid
			assign next_w[g] = cells_q[g+1];
		end
		assign match_d[g] = (cells_q[g] == value) && (CW'(g) < count_q);
		// cells at or after the first match move toward the front
		assign gap_w[g]   = |match_q[g:0];
		assign tail_w[g]  = (CW'(g) == count_m1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			unique case (cmd.op)
				DP_INSERT:    cells_q[i] <= prev_w[i];
				DP_POP_FRONT: cells_q[i] <= next_w[i];
				DP_REMOVE:    if (gap_w[i]) cells_q[i] <= next_w[i];
				DP_ROTATE:    cells_q[i] <= tail_w[i] ? cells_q[0] : next_w[i];
				DP_NONE, DP_MATCH, DP_POP_BACK, DP_DUMP_START: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (cmd.op)
				DP_INSERT:     count_q <= count_q + CW'(1);
				DP_MATCH:      match_q <= match_d;
				DP_REMOVE,
				DP_POP_FRONT,
				DP_POP_BACK:   count_q <= count_m1;
				DP_DUMP_START: idx_q   <= '0;
				DP_ROTATE:     idx_q   <= idx_q + IW'(1);
				DP_NONE: ;
			endcase
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.found     = |match_q;
	assign stat.dump_last = (CW'(idx_q) == count_m1);
	assign front          = cells_q[0];

endmodule

@@ design/olvd_ctrl.sv @@
`timescale 1ns / 1ps

module olvd_ctrl import olvd_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  in_item_t                     in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output out_item_t                    out_item,
	output dp_cmd_t                      dp_cmd,
	input  dp_stat_t                     dp_stat,
	input  logic signed [ValueWidth-1:0] front
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_DUMP
	} state_t;

	state_t    state_q;
	state_t    state_d;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      emit;
	out_item_t emit_item;
	logic      out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		state_d          = state_q;
		emit             = 1'b0;
		emit_item.status = ST_OK;
		emit_item.entry  = '0;
		emit_item.last   = 1'b1;
		dp_cmd.op        = DP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					emit = 1'b1;
					unique case (in_item.cmd)
						CMD_INSERT: begin
							if (dp_stat.full) emit_item.status = ST_FULL;
							else dp_cmd.op = DP_INSERT;
						end
						CMD_DEL_MATCH: begin
							if (dp_stat.empty) begin
								emit_item.status = ST_EMPTY;
							end else begin
								emit      = 1'b0;
								dp_cmd.op = DP_MATCH;
								state_d   = S_REMOVE;
							end
						end
						CMD_DEL_FIRST: begin
							if (dp_stat.empty) emit_item.status = ST_EMPTY;
							else dp_cmd.op = DP_POP_FRONT;
						end
						CMD_DEL_LAST: begin
							if (dp_stat.empty) emit_item.status = ST_EMPTY;
							else dp_cmd.op = DP_POP_BACK;
						end
						CMD_DUMP: begin
							if (dp_stat.empty) begin
								emit_item.status = ST_EMPTY;
							end else begin
								emit      = 1'b0;
								dp_cmd.op = DP_DUMP_START;
								state_d   = S_DUMP;
							end
						end
						default: ;
					endcase
				end
			end
			S_REMOVE: begin
				emit    = 1'b1;
				state_d = S_IDLE;
				if (dp_stat.found) dp_cmd.op = DP_REMOVE;
				else emit_item.status = ST_MISSING;
			end
			S_DUMP: begin
				if (out_free) begin
					// hand out the front cell, then rotate it to the back
					emit            = 1'b1;
					emit_item.entry = front;
					emit_item.last  = dp_stat.dump_last;
					dp_cmd.op       = DP_ROTATE;
					if (dp_stat.dump_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_item_q  <= emit_item;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
